@@ hdl/ipatv_pkg.sv @@
package ipatv_pkg;

  // address classes carried on the result word
  typedef enum logic [1:0] {
    CLASS_NONE = 2'd0,
    CLASS_IPV4 = 2'd1,
    CLASS_IPV6 = 2'd2
  } addr_class_t;

  // separators and digit ranges
  localparam logic [7:0] CHAR_DOT   = 8'h2e;
  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF    = 8'h66;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;

  // IPv4 rules
  localparam logic [2:0] V4_FIELDS     = 3'd4;
  localparam logic [2:0] V4_MAX_DIGITS = 3'd3;
  localparam logic [2:0] V4_COUNT_SAT  = 3'd7;
  localparam logic [9:0] V4_LIMIT      = 10'd256;

  // IPv6 rules
  localparam logic [3:0] V6_GROUPS     = 4'd8;
  localparam logic [2:0] V6_MAX_DIGITS = 3'd4;
  localparam logic [3:0] V6_COUNT_SAT  = 4'd15;

  // one step of work handed from the input register to the scanner
  typedef struct packed {
    logic       step;
    logic       eos;
    logic [7:0] chr;
  } scan_req_t;

endpackage

@@ hdl/ipatv_scan.sv @@
module ipatv_scan (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ipatv_pkg::scan_req_t  req,
  output ipatv_pkg::addr_class_t cls
);

  // per-string tracking state
  logic       dot_seen_r,  dot_seen_nxt;
  logic       v4_ok_r,     v4_ok_nxt;
  logic [2:0] v4_fields_r, v4_fields_nxt;
  logic [2:0] v4_digits_r, v4_digits_nxt;
  logic [9:0] v4_value_r,  v4_value_nxt;
  logic       v4_zero_r,   v4_zero_nxt;
  logic       v6_ok_r,     v6_ok_nxt;
  logic [3:0] v6_groups_r, v6_groups_nxt;
  logic [2:0] v6_digits_r, v6_digits_nxt;

  // character decode
  logic       is_dec;
  logic       is_hex;
  logic [9:0] digit_val;
  assign is_dec = (req.chr >= ipatv_pkg::CHAR_0) && (req.chr <= ipatv_pkg::CHAR_9);
  assign is_hex = is_dec ||
                  ((req.chr >= ipatv_pkg::CHAR_LA) && (req.chr <= ipatv_pkg::CHAR_LF)) ||
                  ((req.chr >= ipatv_pkg::CHAR_UA) && (req.chr <= ipatv_pkg::CHAR_UF));
  assign digit_val = {6'd0, req.chr[3:0]};

  // field / group close terms, shared by separators and end of string
  logic       v4_close_ok;
  logic [2:0] v4_fields_inc;
  logic [3:0] v6_groups_inc;
  assign v4_close_ok = (v4_digits_r != 3'd0) && (v4_value_r < ipatv_pkg::V4_LIMIT) &&
                       !(v4_zero_r && (v4_digits_r > 3'd1));
  assign v4_fields_inc = (v4_fields_r < ipatv_pkg::V4_COUNT_SAT) ?
                         v4_fields_r + 3'd1 : v4_fields_r;
  assign v6_groups_inc = (v6_groups_r < ipatv_pkg::V6_COUNT_SAT) ?
                         v6_groups_r + 4'd1 : v6_groups_r;

  // verdict at end of string
  always_comb begin
    cls = ipatv_pkg::CLASS_NONE;
    if (dot_seen_r) begin
      if (v4_ok_r && v4_close_ok && (v4_fields_inc == ipatv_pkg::V4_FIELDS))
        cls = ipatv_pkg::CLASS_IPV4;
    end else begin
      if (v6_ok_r && (v6_digits_r != 3'd0) && (v6_groups_inc == ipatv_pkg::V6_GROUPS))
        cls = ipatv_pkg::CLASS_IPV6;
    end
  end

  // state update for one character, or clear at an end-of-string word
  always_comb begin
    dot_seen_nxt  = dot_seen_r;
    v4_ok_nxt     = v4_ok_r;
    v4_fields_nxt = v4_fields_r;
    v4_digits_nxt = v4_digits_r;
    v4_value_nxt  = v4_value_r;
    v4_zero_nxt   = v4_zero_r;
    v6_ok_nxt     = v6_ok_r;
    v6_groups_nxt = v6_groups_r;
    v6_digits_nxt = v6_digits_r;

    if (req.eos) begin
      dot_seen_nxt  = 1'b0;
      v4_ok_nxt     = 1'b1;
      v4_fields_nxt = 3'd0;
      v4_digits_nxt = 3'd0;
      v4_value_nxt  = 10'd0;
      v4_zero_nxt   = 1'b0;
      v6_ok_nxt     = 1'b1;
      v6_groups_nxt = 4'd0;
      v6_digits_nxt = 3'd0;
    end else begin
      // IPv4 side
      if (req.chr == ipatv_pkg::CHAR_DOT) begin
        dot_seen_nxt  = 1'b1;
        if (!v4_close_ok) v4_ok_nxt = 1'b0;
        v4_fields_nxt = v4_fields_inc;
        v4_digits_nxt = 3'd0;
        v4_value_nxt  = 10'd0;
        v4_zero_nxt   = 1'b0;
      end else if (is_dec) begin
        if (v4_digits_r >= ipatv_pkg::V4_MAX_DIGITS) begin
          v4_ok_nxt = 1'b0;
        end else begin
          if (v4_digits_r == 3'd0) v4_zero_nxt = (req.chr == ipatv_pkg::CHAR_0);
          // value*10 + digit; value stays below 100 here
          v4_value_nxt  = (v4_value_r << 3) + (v4_value_r << 1) + digit_val;
          v4_digits_nxt = v4_digits_r + 3'd1;
        end
      end else begin
        v4_ok_nxt = 1'b0;
      end

      // IPv6 side
      if (req.chr == ipatv_pkg::CHAR_COLON) begin
        if (v6_digits_r == 3'd0) v6_ok_nxt = 1'b0;
        v6_groups_nxt = v6_groups_inc;
        v6_digits_nxt = 3'd0;
      end else if (is_hex) begin
        if (v6_digits_r >= ipatv_pkg::V6_MAX_DIGITS) v6_ok_nxt = 1'b0;
        else v6_digits_nxt = v6_digits_r + 3'd1;
      end else begin
        v6_ok_nxt = 1'b0;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_seen_r  <= 1'b0;
      v4_ok_r     <= 1'b1;
      v4_fields_r <= 3'd0;
      v4_digits_r <= 3'd0;
      v4_value_r  <= 10'd0;
      v4_zero_r   <= 1'b0;
      v6_ok_r     <= 1'b1;
      v6_groups_r <= 4'd0;
      v6_digits_r <= 3'd0;
    end else if (req.step) begin
      dot_seen_r  <= dot_seen_nxt;
      v4_ok_r     <= v4_ok_nxt;
      v4_fields_r <= v4_fields_nxt;
      v4_digits_r <= v4_digits_nxt;
      v4_value_r  <= v4_value_nxt;
      v4_zero_r   <= v4_zero_nxt;
      v6_ok_r     <= v6_ok_nxt;
      v6_groups_r <= v6_groups_nxt;
      v6_digits_r <= v6_digits_nxt;
    end
  end

endmodule

@@ hdl/ip_address_text_validator.sv @@
// Timing: a character word updates the scan state in the cycle after it is registered;
//   an end-of-string word raises out_valid with its class once it leaves the input register.
// Throughput: one word per cycle, given by the scan update; the input
//   register stalls only while an end-of-string result waits on a full output register.
// Reset: synchronous active-low rst_n empties both registers and returns the scan
//   state to the start of a string.
module ip_address_text_validator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_character,
  input  logic       in_end_of_string,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_address_class
);

  // input register
  logic       in_valid_r;
  logic [7:0] chr_r;
  logic       eos_r;

  // output register
  logic       out_valid_r;
  logic [1:0] class_r;

  logic                   out_free;
  logic                   advance;
  ipatv_pkg::scan_req_t   req;
  ipatv_pkg::addr_class_t cls;

  // a character word always advances; an end word needs room at the output
  assign out_free = !out_valid_r || out_ready;
  assign advance  = in_valid_r && (!eos_r || out_free);
  assign in_ready = !in_valid_r || advance;

  assign req.step = advance;
  assign req.eos  = eos_r;
  assign req.chr  = chr_r;

  ipatv_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .cls   (cls)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      chr_r <= in_character;
      eos_r <= in_end_of_string;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && eos_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && eos_r) begin
      class_r <= cls;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_address_class = class_r;

  // end word advancing always produces a result next cycle
  a_eos_result: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && eos_r) |=> out_valid_r)
    else $error("end word advanced without a result");

  // no result appears unless an end word advanced
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (out_free && !(in_valid_r && eos_r)) |=> !out_valid_r)
    else $error("result without an end word");

  // class code is one of the three defined values
  a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (class_r != 2'd3))
    else $error("bad address class");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int RUN_ITEMS   = 1900;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PREDICTED   = -1;
  localparam int DIR_N       = 22;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_character;
  logic       in_end_of_string;
  logic       out_valid;
  logic       out_ready;
  logic [1:0] out_address_class;

  ip_address_text_validator DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_character     (in_character),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_address_class(out_address_class)
  );

  // directed strings; a class is typed in where it is obvious, else predicted
  string dir_text [DIR_N] = '{
    "",
    "0.0.0.0",
    "255.255.255.255",
    "256.0.0.0",
    "999.1.1.1",
    "01.2.3.4",
    "1.2.3",
    "1.2.3.4.5",
    "1.2.3.4.5.6.7.8.9",
    "1234.1.1.1",
    "1..2.3",
    "1.2.3.4.",
    "0:0:0:0:0:0:0:0",
    "ffff:FFFF:aBcD:0:9:A:f:F",
    "1:2:3:4:5:6:7",
    "1::2:3:4:5:6:7",
    "12345:1:1:1:1:1:1:1",
    "1:2:3:4:5:6:7:8:9:a:b:c:d:e:f:0:1",
    "g:1:1:1:1:1:1:1",
    "1.2.3.4:5",
    "\377",
    "1:2:3:4:5:6:7:8\377"
  };
  int dir_class [DIR_N] = '{
    ipatv_pkg::CLASS_NONE, ipatv_pkg::CLASS_IPV4, ipatv_pkg::CLASS_IPV4,
    ipatv_pkg::CLASS_NONE, ipatv_pkg::CLASS_NONE,
    PREDICTED, PREDICTED, PREDICTED, PREDICTED, PREDICTED, PREDICTED, PREDICTED,
    ipatv_pkg::CLASS_IPV6, ipatv_pkg::CLASS_IPV6,
    PREDICTED, PREDICTED, PREDICTED, PREDICTED, PREDICTED, PREDICTED,
    ipatv_pkg::CLASS_NONE, PREDICTED
  };

  // scan state of the predictor
  logic       sc_dot;
  logic       v4_ok;
  logic [2:0] v4_fields;
  logic [2:0] v4_digits;
  logic [9:0] v4_value;
  logic       v4_lead_zero;
  logic       v6_ok;
  logic [3:0] v6_groups;
  logic [2:0] v6_digits;

  ipatv_pkg::addr_class_t pending_class[$];
  logic [7:0]             text_q[$];
  int                     sent_items;
  int                     fail_count;
  int                     cycle_count;
  bit                     smooth;
  bit                     hold_req;

  function automatic void scan_clear();
    sc_dot       = 1'b0;
    v4_ok        = 1'b1;
    v4_fields    = '0;
    v4_digits    = '0;
    v4_value     = '0;
    v4_lead_zero = 1'b0;
    v6_ok        = 1'b1;
    v6_groups    = '0;
    v6_digits    = '0;
  endfunction

  function automatic void v4_close();
    if (v4_digits == 0 || v4_value >= ipatv_pkg::V4_LIMIT ||
        (v4_lead_zero && v4_digits > 1))
      v4_ok = 1'b0;
    if (v4_fields < ipatv_pkg::V4_COUNT_SAT) v4_fields = v4_fields + 1'b1;
    v4_digits    = '0;
    v4_value     = '0;
    v4_lead_zero = 1'b0;
  endfunction

  function automatic void v6_close();
    if (v6_digits == 0) v6_ok = 1'b0;
    if (v6_groups < ipatv_pkg::V6_COUNT_SAT) v6_groups = v6_groups + 1'b1;
    v6_digits = '0;
  endfunction

  // advance the scan by one word; returns 1 when the word yields a class
  function automatic bit scan_word(input logic [7:0] c, input logic eos,
                                   output ipatv_pkg::addr_class_t cls);
    bit is_dec;
    bit is_hex;
    cls = ipatv_pkg::CLASS_NONE;
    if (eos) begin
      v4_close();
      v6_close();
      if (sc_dot) begin
        if (v4_ok && v4_fields == ipatv_pkg::V4_FIELDS) cls = ipatv_pkg::CLASS_IPV4;
      end else if (v6_ok && v6_groups == ipatv_pkg::V6_GROUPS) begin
        cls = ipatv_pkg::CLASS_IPV6;
      end
      scan_clear();
      return 1'b1;
    end
    is_dec = (c >= ipatv_pkg::CHAR_0 && c <= ipatv_pkg::CHAR_9);
    is_hex = is_dec ||
             (c >= ipatv_pkg::CHAR_LA && c <= ipatv_pkg::CHAR_LF) ||
             (c >= ipatv_pkg::CHAR_UA && c <= ipatv_pkg::CHAR_UF);
    // IPv4 side
    if (c == ipatv_pkg::CHAR_DOT) begin
      sc_dot = 1'b1;
      v4_close();
    end else if (is_dec) begin
      if (v4_digits >= ipatv_pkg::V4_MAX_DIGITS) begin
        v4_ok = 1'b0;
      end else begin
        if (v4_digits == 0) v4_lead_zero = (c == ipatv_pkg::CHAR_0);
        v4_value  = v4_value * 10'd10 + {2'b00, c - ipatv_pkg::CHAR_0};
        v4_digits = v4_digits + 1'b1;
      end
    end else begin
      v4_ok = 1'b0;
    end
    // IPv6 side
    if (c == ipatv_pkg::CHAR_COLON) begin
      v6_close();
    end else if (is_hex) begin
      if (v6_digits >= ipatv_pkg::V6_MAX_DIGITS) v6_ok = 1'b0;
      else v6_digits = v6_digits + 1'b1;
    end else begin
      v6_ok = 1'b0;
    end
    return 1'b0;
  endfunction

  // clock and cycle limit
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    ipatv_pkg::addr_class_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_class.size() == 0) begin
        $display("%0t: unexpected class word, expected none, actual %0d", $time,
                 out_address_class);
        fail_count++;
      end else begin
        want = pending_class.pop_front();
        if (out_address_class !== want) begin
          $display("%0t: address_class mismatch, expected %0d, actual %0d", $time,
                   want, out_address_class);
          fail_count++;
        end
      end
    end
  end

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    int r;
    int n;
    bit lvl;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (smooth || r < 60) begin
          lvl = 1'b1;
          n   = $urandom_range(1, 8);
        end else if (r < 92) begin
          lvl = 1'b0;
          n   = $urandom_range(1, 3);
        end else begin
          lvl = 1'b0;
          n   = $urandom_range(5, 25);
        end
        out_ready <= lvl;
        repeat (n) @(posedge clk);
      end
    end
  end

  // offer one word and wait for it to be taken; predict at acceptance
  task automatic send_word(input logic [7:0] c, input logic eos, input int typed);
    ipatv_pkg::addr_class_t cls;
    in_valid         <= 1'b1;
    in_character     <= c;
    in_end_of_string <= eos;
    do @(posedge clk); while (!in_ready);
    sent_items++;
    if (scan_word(c, eos, cls)) begin
      if (typed >= 0) pending_class.push_back(ipatv_pkg::addr_class_t'(typed));
      else pending_class.push_back(cls);
    end
  endtask

  task automatic sender_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (smooth || r < 70) n = 0;
    else if (r < 95) n = $urandom_range(1, 3);
    else n = $urandom_range(5, 30);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // pause the sender until every pending class has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_class.size() != 0);
  endtask

  task automatic send_text(input int typed);
    foreach (text_q[i]) begin
      send_word(text_q[i], 1'b0, typed);
      sender_gap();
    end
    send_word(8'($urandom_range(0, 255)), 1'b1, typed);
    sender_gap();
  endtask

  function automatic logic [7:0] pick_byte();
    string odd_chars;
    odd_chars = "0123456789.:abcdefABCDEFgG/@` ";
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
    return odd_chars[$urandom_range(0, odd_chars.len() - 1)];
  endfunction

  function automatic logic [7:0] hex_char();
    int k;
    k = $urandom_range(0, 21);
    if (k < 10) return ipatv_pkg::CHAR_0 + 8'(k);
    if (k < 16) return ipatv_pkg::CHAR_LA + 8'(k - 10);
    return ipatv_pkg::CHAR_UA + 8'(k - 16);
  endfunction

  function automatic void add_dec(input int unsigned v);
    string s;
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic void build_v4();
    int n;
    int r;
    n = ($urandom_range(0, 99) < 85) ? 4 : $urandom_range(1, 9);
    for (int f = 0; f < n; f++) begin
      if (f > 0) text_q.push_back(ipatv_pkg::CHAR_DOT);
      r = $urandom_range(0, 99);
      if (r < 80) begin
        add_dec($urandom_range(0, 255));
      end else if (r < 88) begin
        add_dec($urandom_range(256, 999));
      end else if (r < 95) begin
        // leading zero
        text_q.push_back(ipatv_pkg::CHAR_0);
        add_dec($urandom_range(0, 99));
      end
    end
  endfunction

  function automatic void build_v6();
    int n;
    int r;
    int d;
    n = ($urandom_range(0, 99) < 85) ? 8 : $urandom_range(1, 17);
    for (int g = 0; g < n; g++) begin
      if (g > 0) text_q.push_back(ipatv_pkg::CHAR_COLON);
      r = $urandom_range(0, 99);
      d = (r < 92) ? $urandom_range(1, 4) : ((r < 96) ? 0 : 5);
      repeat (d) text_q.push_back(hex_char());
    end
  endfunction

  // change a generated string by one replace, insert or delete
  function automatic void mangle();
    int op;
    int pos;
    op = $urandom_range(0, 2);
    if (text_q.size() == 0) op = 1;
    pos = (text_q.size() == 0) ? 0 : $urandom_range(0, text_q.size() - 1);
    unique case (op)
      0: text_q[pos] = pick_byte();
      1: text_q.insert(pos, pick_byte());
      default: text_q.delete(pos);
    endcase
  endfunction

  // sender: directed strings, then random ones
  initial begin
    int r;
    int burst_left;
    bit hold_started;
    bit mid_drained;
    string s;
    in_valid         <= 1'b0;
    in_character     <= '0;
    in_end_of_string <= 1'b0;
    rst_n            <= 1'b0;
    cycle_count      = 0;
    sent_items       = 0;
    fail_count       = 0;
    smooth           = 1'b0;
    hold_req         = 1'b0;
    hold_started     = 1'b0;
    mid_drained      = 1'b0;
    burst_left       = 0;
    scan_clear();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      s = dir_text[i];
      text_q.delete();
      for (int k = 0; k < s.len(); k++) text_q.push_back(s[k]);
      send_text(dir_class[i]);
    end
    drain();

    while (sent_items < RUN_ITEMS) begin
      // one long receiver hold-off while the sender keeps pushing
      if (!hold_started && sent_items >= 800) begin
        hold_req     = 1'b1;
        hold_started = 1'b1;
        burst_left   = 25;
      end
      if (!mid_drained && sent_items >= 1400) begin
        mid_drained = 1'b1;
        drain();
      end
      smooth = (burst_left > 0) || ($urandom_range(0, 7) == 0);
      if (burst_left > 0) burst_left--;

      text_q.delete();
      r = $urandom_range(0, 99);
      if (r < 45) build_v4();
      else if (r < 80) build_v6();
      else repeat ($urandom_range(0, 12)) text_q.push_back(pick_byte());
      if (r < 80 && $urandom_range(0, 99) < 25) mangle();
      send_text(PREDICTED);
    end

    smooth = 1'b0;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_class.size() != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
